// ===== sv/imu_lat_pkg.sv =====
// Shared types and constants for the IMU lever-arm transform.
// No dependencies; compile first.
`timescale 1ns / 1ps

package imu_lat_pkg;

    localparam int unsigned FIELD_W               = 54;
    localparam int unsigned DEFAULT_COMPONENT_WIDTH = 18;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_MOUNT_ROT_ROW0 = 2'd0,
        CFG_MOUNT_ROT_ROW1 = 2'd1,
        CFG_MOUNT_ROT_ROW2 = 2'd2,
        CFG_MOUNT_OFFSET   = 2'd3
    } cfg_index_t;

    typedef logic [FIELD_W-1:0] field_t;

    typedef struct packed {
        field_t body_rot_row0;
        field_t body_rot_row1;
        field_t body_rot_row2;
        field_t global_rate;
        field_t global_accel;
        field_t global_rate_dot;
    } in_beat_t;

    typedef struct packed {
        field_t sensor_rate;
        field_t sensor_accel;
    } out_beat_t;

endpackage

// ===== sv/imu_lat_stream_if.sv =====
// Valid/ready stream interface carrying one beat of a given payload type.
// Payload types come from imu_lat_pkg.
`timescale 1ns / 1ps

interface imu_lat_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/imu_frame_lever_arm_transform.sv =====
// IMU lever-arm transform top level: 8-stage pipeline, one sample per cycle unless stalled.
// Depends on imu_lat_pkg and imu_lat_stream_if.
`timescale 1ns / 1ps

// Turns global-frame body motion into what a mounted IMU reads. Each beat on
// sample_in carries the body rotation rows, angular rate, linear acceleration
// and angular acceleration; each beat on sample_out carries the sensor-frame
// rate and the saturated sensor-frame acceleration, including the lever-arm
// terms. Throughput is one sample per clock unless the output stalls; there
// are eight register stages (multiply, reduce, multiply, reduce, cross
// multiply, reduce, cross multiply, sum/saturate). The whole pipeline stalls
// together while the output beat is held. The user must write mount registers
// through cfg_* only while no samples are in flight; the block does not enforce it.
module imu_frame_lever_arm_transform
#(
    parameter int unsigned COMPONENT_WIDTH = imu_lat_pkg::DEFAULT_COMPONENT_WIDTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  imu_lat_pkg::cfg_index_t     cfg_index,
    input  imu_lat_pkg::field_t         cfg_data,
    imu_lat_stream_if.sink              sample_in,
    imu_lat_stream_if.source            sample_out
);
    import imu_lat_pkg::*;

    localparam int W    = COMPONENT_WIDTH;
    localparam int RF   = W - 2;     // rotation fraction bits
    localparam int VF   = W - 10;    // rate/accel fraction bits
    localparam int OF   = W - 4;     // offset fraction bits
    localparam int V    = W + 17;    // kept-wide intermediate width
    localparam int WIDE = 2 * W + 20; // product / sum width
    localparam int PW   = (3 * W > FIELD_W) ? 3 * W : FIELD_W;
    localparam int NST  = 8;

    localparam logic signed [WIDE-1:0] CMAX = WIDE'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [WIDE-1:0] CMIN = -CMAX - WIDE'(1);

    localparam logic [PW-1:0] ONE_X = PW'(1) << RF;
    localparam logic [PW-1:0] ONE_Y = ONE_X << W;
    localparam logic [PW-1:0] ONE_Z = ONE_X << (2 * W);
    localparam field_t ROT_ROW0_RST = ONE_X[FIELD_W-1:0];
    localparam field_t ROT_ROW1_RST = ONE_Y[FIELD_W-1:0];
    localparam field_t ROT_ROW2_RST = ONE_Z[FIELD_W-1:0];

    typedef logic signed [W-1:0]    comp_t;
    typedef logic signed [V-1:0]    vcomp_t;
    typedef logic signed [WIDE-1:0] wide_t;

    function automatic comp_t comp(input field_t fld, input int k);
        logic [PW-1:0] e;
        e = PW'(fld);
        return comp_t'(e[k*W +: W]);
    endfunction

    function automatic field_t pack(input comp_t c0, input comp_t c1, input comp_t c2);
        logic [PW-1:0] p;
        p = '0;
        p[0 +: W]   = c0;
        p[W +: W]   = c1;
        p[2*W +: W] = c2;
        return p[FIELD_W-1:0];
    endfunction

    // round half up, then arithmetic shift
    function automatic wide_t rnd(input wide_t x, input int s);
        logic signed [WIDE:0] y;
        y = (WIDE+1)'(x) + ((WIDE+1)'(1) <<< (s - 1));
        return WIDE'(y >>> s);
    endfunction

    function automatic comp_t sat(input wide_t x);
        wide_t y;
        y = x;
        if (x > CMAX)
        begin
            y = CMAX;
        end
        else if (x < CMIN)
        begin
            y = CMIN;
        end
        return comp_t'(y);
    endfunction

    // kept-wide operand times one component
    function automatic wide_t mul(input vcomp_t a, input comp_t b);
        logic signed [V+W-1:0] p;
        p = a * b;
        return WIDE'(p);
    endfunction

    // ---------------- configuration registers ----------------
    field_t mrot0_reg, mrot1_reg, mrot2_reg, moff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mrot0_reg <= ROT_ROW0_RST;
            mrot1_reg <= ROT_ROW1_RST;
            mrot2_reg <= ROT_ROW2_RST;
            moff_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MOUNT_ROT_ROW0: mrot0_reg <= cfg_data;
                CFG_MOUNT_ROT_ROW1: mrot1_reg <= cfg_data;
                CFG_MOUNT_ROT_ROW2: mrot2_reg <= cfg_data;
                CFG_MOUNT_OFFSET:   moff_reg  <= cfg_data;
                default:            ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // Global stall: every stage moves when the output beat is free or taken.
    logic [NST:1] v_reg;
    logic         en;

    assign en              = !v_reg[NST] || sample_out.ready;
    assign sample_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NST-1:1], sample_in.valid};
        end
    end

    // ---------------- unpacked inputs ----------------
    comp_t b[3][3], m[3][3], off[3], w_in[3], a_in[3], d_in[3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            b[0][k]  = comp(sample_in.data.body_rot_row0, k);
            b[1][k]  = comp(sample_in.data.body_rot_row1, k);
            b[2][k]  = comp(sample_in.data.body_rot_row2, k);
            m[0][k]  = comp(mrot0_reg, k);
            m[1][k]  = comp(mrot1_reg, k);
            m[2][k]  = comp(mrot2_reg, k);
            off[k]   = comp(moff_reg, k);
            w_in[k]  = comp(sample_in.data.global_rate, k);
            a_in[k]  = comp(sample_in.data.global_accel, k);
            d_in[k]  = comp(sample_in.data.global_rate_dot, k);
        end
    end

    // ---------------- stage registers ----------------
    wide_t  bm_reg[3][3][3];   // b[i][k]*m[k][j]
    wide_t  mo_reg[3][3];      // m[k][j]*off[k]
    comp_t  w1_reg[3], a1_reg[3], d1_reg[3];
    comp_t  r2_reg[3][3], f2_reg[3], w2_reg[3], a2_reg[3], d2_reg[3];
    wide_t  rw3_reg[3][3], ra3_reg[3][3], rd3_reg[3][3];
    comp_t  f3_reg[3];
    comp_t  ws4_reg[3], f4_reg[3];
    vcomp_t as4_reg[3], ps4_reg[3];
    wide_t  pf5_reg[3][2], wf5_reg[3][2];
    comp_t  ws5_reg[3];
    vcomp_t as5_reg[3];
    vcomp_t t16_reg[3], u6_reg[3], as6_reg[3];
    comp_t  ws6_reg[3];
    wide_t  wu7_reg[3][2];
    vcomp_t t17_reg[3], as7_reg[3];
    comp_t  ws7_reg[3];
    out_beat_t out_reg;

    // stage-combinational results
    comp_t  r_next[3][3], f_next[3], ws_next[3];
    vcomp_t as_next[3], ps_next[3], t1_next[3], u_next[3];
    comp_t  acc_next[3];
    wide_t  sum;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                r_next[i][j] = sat(rnd(bm_reg[i][0][j] + bm_reg[i][1][j]
                                       + bm_reg[i][2][j], RF));
            end
            f_next[i] = sat(rnd(mo_reg[0][i] + mo_reg[1][i] + mo_reg[2][i], RF));
            ws_next[i] = sat(rnd(rw3_reg[0][i] + rw3_reg[1][i] + rw3_reg[2][i], RF));
            as_next[i] = vcomp_t'(rnd(ra3_reg[0][i] + ra3_reg[1][i] + ra3_reg[2][i], RF));
            ps_next[i] = vcomp_t'(rnd(rd3_reg[0][i] + rd3_reg[1][i] + rd3_reg[2][i], RF));
            t1_next[i] = vcomp_t'(rnd(pf5_reg[i][0] - pf5_reg[i][1], OF));
            u_next[i]  = vcomp_t'(rnd(wf5_reg[i][0] - wf5_reg[i][1], VF));
            sum = WIDE'(as7_reg[i]) + WIDE'(t17_reg[i])
                  + rnd(wu7_reg[i][0] - wu7_reg[i][1], OF);
            acc_next[i] = sat(sum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                // stage 1: R and f products
                for (int k = 0; k < 3; k++)
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        bm_reg[i][k][j] <= mul(vcomp_t'(b[i][k]), m[k][j]);
                    end
                    mo_reg[k][i] <= mul(vcomp_t'(m[k][i]), off[k]);
                end
                w1_reg[i] <= w_in[i];
                a1_reg[i] <= a_in[i];
                d1_reg[i] <= d_in[i];
                // stage 2: R, f
                for (int j = 0; j < 3; j++)
                begin
                    r2_reg[i][j] <= r_next[i][j];
                end
                f2_reg[i] <= f_next[i];
                w2_reg[i] <= w1_reg[i];
                a2_reg[i] <= a1_reg[i];
                d2_reg[i] <= d1_reg[i];
                // stage 3: R^T products
                for (int k = 0; k < 3; k++)
                begin
                    rw3_reg[k][i] <= mul(vcomp_t'(r2_reg[k][i]), w2_reg[k]);
                    ra3_reg[k][i] <= mul(vcomp_t'(r2_reg[k][i]), a2_reg[k]);
                    rd3_reg[k][i] <= mul(vcomp_t'(r2_reg[k][i]), d2_reg[k]);
                end
                f3_reg[i] <= f2_reg[i];
                // stage 4: w', R^T a, R^T wdot
                ws4_reg[i] <= ws_next[i];
                as4_reg[i] <= as_next[i];
                ps4_reg[i] <= ps_next[i];
                f4_reg[i]  <= f3_reg[i];
                // stage 5: cross products with f
                pf5_reg[i][0] <= mul(ps4_reg[(i+1)%3], f4_reg[(i+2)%3]);
                pf5_reg[i][1] <= mul(ps4_reg[(i+2)%3], f4_reg[(i+1)%3]);
                wf5_reg[i][0] <= mul(vcomp_t'(ws4_reg[(i+1)%3]), f4_reg[(i+2)%3]);
                wf5_reg[i][1] <= mul(vcomp_t'(ws4_reg[(i+2)%3]), f4_reg[(i+1)%3]);
                ws5_reg[i] <= ws4_reg[i];
                as5_reg[i] <= as4_reg[i];
                // stage 6: t1, u
                t16_reg[i] <= t1_next[i];
                u6_reg[i]  <= u_next[i];
                ws6_reg[i] <= ws5_reg[i];
                as6_reg[i] <= as5_reg[i];
                // stage 7: w' x u products
                wu7_reg[i][0] <= mul(u6_reg[(i+2)%3], ws6_reg[(i+1)%3]);
                wu7_reg[i][1] <= mul(u6_reg[(i+1)%3], ws6_reg[(i+2)%3]);
                ws7_reg[i] <= ws6_reg[i];
                as7_reg[i] <= as6_reg[i];
                t17_reg[i] <= t16_reg[i];
            end
            // stage 8: output beat
            out_reg.sensor_rate  <= pack(ws7_reg[0], ws7_reg[1], ws7_reg[2]);
            out_reg.sensor_accel <= pack(acc_next[0], acc_next[1], acc_next[2]);
        end
    end

    assign sample_out.valid = v_reg[NST];
    assign sample_out.data  = out_reg;

    // ---------------- assertions ----------------
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        en && v_reg[NST-1] |=> sample_out.valid)
        else $error("stage 7 beat did not reach the output");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("pipeline valids moved during a stall");

    a_rate_path: assert property (@(posedge clk) disable iff (!rst_n)
        en && v_reg[NST-1] |=>
            sample_out.data.sensor_rate == $past(pack(ws7_reg[0], ws7_reg[1], ws7_reg[2])))
        else $error("sensor rate mismatch at output stage");

endmodule
